FILE: hw/rtl/frh_pkg.sv
// Shared types, character constants and helper functions for the relay command handler.
// No dependencies; imported by every module of the block.
package frh_pkg;

    // Block sizing
    localparam int OPTO_COUNT  = 4;
    localparam int RELAY_COUNT = 8;
    localparam int KEEP_CHARS  = 10;
    localparam int REPLY_LEN   = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] OPTO_MASK  = 8'((9'd1 << OPTO_COUNT) - 9'd1);
    localparam logic [7:0] RELAY_MASK = 8'((9'd1 << RELAY_COUNT) - 9'd1);

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;

    // Configuration register indexes
    localparam logic [7:0] REG_OWN_TAG      = 8'd0;
    localparam logic [7:0] REG_OWN_ADDRESS  = 8'd1;
    localparam logic [7:0] REG_SET_ACTION   = 8'd2;
    localparam logic [7:0] REG_REPLY_ACTION = 8'd3;

    // Reply frame byte positions
    localparam logic [3:0] FB_OPEN   = 4'd0;
    localparam logic [3:0] FB_C3     = 4'd1;
    localparam logic [3:0] FB_C4     = 4'd2;
    localparam logic [3:0] FB_C1     = 4'd3;
    localparam logic [3:0] FB_C2     = 4'd4;
    localparam logic [3:0] FB_C5     = 4'd5;
    localparam logic [3:0] FB_C6     = 4'd6;
    localparam logic [3:0] FB_ACTION = 4'd7;
    localparam logic [3:0] FB_STATUS = 4'd8;
    localparam logic [3:0] FB_CLOSE  = 4'd9;
    localparam logic [3:0] FB_CR0    = 4'd10;
    localparam logic [3:0] FB_LF0    = 4'd11;
    localparam logic [3:0] FB_CR1    = 4'd12;
    localparam logic [3:0] FB_LF1    = 4'd13;

    // Configuration register set
    typedef struct packed {
        logic [7:0] own_tag;
        logic [7:0] own_address;
        logic [7:0] set_action_code;
        logic [7:0] reply_action_code;
    } cfg_t;

    // One classified command, front to back
    typedef struct packed {
        logic       reply;      // emit a 14-byte frame instead of a single result
        logic [7:0] relay;      // relay state after this item
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [7:0] c4;
        logic [7:0] c5;
        logic [7:0] c6;
        logic [7:0] action;
        logic [7:0] status;     // masked opto bits plus '0'
    } cmd_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Back end status
    typedef struct packed {
        logic mid_frame;        // part of a reply frame already sent
    } back_stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic [7:0] frame_byte(input cmd_t e, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            FB_OPEN:   b = CH_LT;
            FB_C3:     b = e.c3;
            FB_C4:     b = e.c4;
            FB_C1:     b = e.c1;
            FB_C2:     b = e.c2;
            FB_C5:     b = e.c5;
            FB_C6:     b = e.c6;
            FB_ACTION: b = e.action;
            FB_STATUS: b = e.status;
            FB_CLOSE:  b = CH_GT;
            FB_CR0:    b = CH_CR;
            FB_LF0:    b = CH_LF;
            FB_CR1:    b = CH_CR;
            FB_LF1:    b = CH_LF;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/frh_front.sv
// Front end: collects the line, trims whitespace, decodes commands at newline,
// owns the relay register and pushes one classified command per item. Uses frh_pkg.
module frh_front
    import frh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic [7:0] opto_events,
    input  cfg_t       cfg,
    input  q_stat_t    q_stat,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [7:0] chars_reg [KEEP_CHARS];
    logic [7:0] len_reg, len_next;
    logic [7:0] trim_reg, trim_next;
    logic       started_reg, started_next;
    logic [7:0] relay_reg, relay_next;

    logic       chars_we;
    logic       ws;
    logic [7:0] len_inc;
    logic       line_match;
    logic [7:0] relay_idx;
    logic [7:0] relay_bit;
    logic       do_reply;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;
    assign ws       = is_ws(rx_byte);
    assign len_inc  = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;

    // Frame check on the stored line
    assign line_match = (trim_reg >= 8'(KEEP_CHARS)) &&
                        (chars_reg[0] == CH_LT) && (chars_reg[9] == CH_GT) &&
                        (chars_reg[1] == cfg.own_tag) &&
                        (chars_reg[2] == cfg.own_address);
    assign relay_idx = chars_reg[6] - CH_ONE;
    assign relay_bit = RELAY_MASK & (8'd1 << relay_idx[2:0]);

    // Line state and command decode
    always_comb
    begin
        len_next     = len_reg;
        trim_next    = trim_reg;
        started_next = started_reg;
        relay_next   = relay_reg;
        chars_we     = 1'b0;
        do_reply     = 1'b0;
        if (push)
        begin
            if (rx_byte != CH_LF)
            begin
                if (started_reg || !ws)
                begin
                    started_next = 1'b1;
                    chars_we     = (len_reg < 8'(KEEP_CHARS));
                    len_next     = len_inc;
                    if (!ws)
                    begin
                        trim_next = len_inc;
                    end
                end
            end
            else
            begin
                if (line_match)
                begin
                    if (chars_reg[5] == CH_S)
                    begin
                        if ((relay_idx < 8'(RELAY_COUNT)) &&
                            (chars_reg[7] == cfg.set_action_code))
                        begin
                            priority if (chars_reg[8] == CH_ZERO)
                                relay_next = relay_reg & ~relay_bit;
                            else if (chars_reg[8] == CH_ONE)
                                relay_next = relay_reg | relay_bit;
                            else if (chars_reg[8] == CH_T)
                                relay_next = relay_reg ^ relay_bit;
                            else
                                relay_next = relay_reg;
                        end
                    end
                    else if ((chars_reg[5] == CH_O) && (chars_reg[6] == CH_STAR))
                    begin
                        do_reply = 1'b1;
                    end
                end
                len_next     = 8'd0;
                trim_next    = 8'd0;
                started_next = 1'b0;
            end
        end
    end

    // Command handed to the queue
    always_comb
    begin
        push_cmd.reply  = do_reply;
        push_cmd.relay  = relay_next & RELAY_MASK;
        push_cmd.c1     = chars_reg[1];
        push_cmd.c2     = chars_reg[2];
        push_cmd.c3     = chars_reg[3];
        push_cmd.c4     = chars_reg[4];
        push_cmd.c5     = chars_reg[5];
        push_cmd.c6     = chars_reg[6];
        push_cmd.action = cfg.reply_action_code;
        push_cmd.status = (opto_events & OPTO_MASK) + CH_ZERO;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= 8'd0;
            trim_reg    <= 8'd0;
            started_reg <= 1'b0;
            relay_reg   <= 8'd0;
        end
        else
        begin
            len_reg     <= len_next;
            trim_reg    <= trim_next;
            started_reg <= started_next;
            relay_reg   <= relay_next;
        end
    end

    // Stored line characters, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEEP_CHARS; i++)
        begin
            if (chars_we && (len_reg[3:0] == 4'(i)))
            begin
                chars_reg[i] <= rx_byte;
            end
        end
    end

endmodule

FILE: hw/rtl/frh_queue.sv
// Two-entry command queue between front and back ends.
// Uses frh_pkg for the command and status types.
module frh_queue
    import frh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == 2'd0);

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/frh_back.sv
// Back end: turns queued commands into result items, one per cycle unless the output
// stalls, through a registered output stage. Uses frh_pkg for frame layout.
module frh_back
    import frh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output back_stat_t back_stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       tx_valid,
    output logic [7:0] relay_bits,
    output logic       last_result
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] tx_reg, tx_next;
    logic       flag_reg, flag_next;
    logic [7:0] relay_reg, relay_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    // Result generation
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        tx_next    = tx_reg;
        flag_next  = flag_reg;
        relay_next = relay_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load && !q_stat.empty)
        begin
            valid_next = 1'b1;
            relay_next = head.relay;
            if (head.reply)
            begin
                tx_next   = frame_byte(head, idx_reg);
                flag_next = 1'b1;
                last_next = (idx_reg == 4'(REPLY_LEN - 1));
                if (idx_reg == 4'(REPLY_LEN - 1))
                begin
                    pop      = 1'b1;
                    idx_next = 4'd0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            else
            begin
                tx_next   = 8'h00;
                flag_next = 1'b0;
                last_next = 1'b1;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        tx_reg    <= tx_next;
        flag_reg  <= flag_next;
        relay_reg <= relay_next;
        last_reg  <= last_next;
    end

    assign back_stat.mid_frame = (idx_reg != 4'd0);
    assign out_valid   = valid_reg;
    assign tx_byte     = tx_reg;
    assign tx_valid    = flag_reg;
    assign relay_bits  = relay_reg;
    assign last_result = last_reg;

endmodule

FILE: hw/rtl/framed_relay_command_handler.sv
// Top level of the framed relay command handler: configuration registers,
// front end, command queue and back end. Uses frh_pkg, frh_front, frh_queue, frh_back.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata = rx_byte[7:0], opto_events[15:8]
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata = tx_byte[7:0], relay_bits[15:8];
//                                              tuser = tx_valid; tlast = last_result
// cfg       in   cfg_valid/cfg_ready           cfg_index (register), cfg_data (value)
//
// One byte is accepted per cycle unless the queue is full; its first result passes
// through a queue entry, then the back end's output register. A reply command yields
// 14 results, one per cycle unless m_axis stalls, from the back end's byte counter.
// The two-entry command queue lets input run on while a reply drains; input stalls
// only when the queue is full. Reset is asynchronous, active low; no clearing pass.
module framed_relay_command_handler
    import frh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], opto_events[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_byte[7:0], relay_bits[15:8]
    output logic        m_axis_tuser,   // tx_valid[0]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    q_stat_t    q_stat;
    back_stat_t back_stat;
    logic [7:0] tx_byte;
    logic [7:0] relay_bits;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OWN_TAG:      cfg_reg.own_tag           <= cfg_data;
                REG_OWN_ADDRESS:  cfg_reg.own_address       <= cfg_data;
                REG_SET_ACTION:   cfg_reg.set_action_code   <= cfg_data;
                REG_REPLY_ACTION: cfg_reg.reply_action_code <= cfg_data;
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    frh_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rx_byte     (s_axis_tdata[7:0]),
        .opto_events (s_axis_tdata[15:8]),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    frh_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    frh_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .back_stat   (back_stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .tx_byte     (tx_byte),
        .tx_valid    (m_axis_tuser),
        .relay_bits  (relay_bits),
        .last_result (m_axis_tlast)
    );

    assign m_axis_tdata = {relay_bits, tx_byte};

    // A result without a reply character is always the only one of its item
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'h00)))
        else $error("plain result not last or carries a character");

    // A reply frame in progress always has its command still queued
    a_frame_queued: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.mid_frame |-> !q_stat.empty)
        else $error("reply frame in progress with empty queue");

    // The queue never pops and pushes past its bounds
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty) && !(push && q_stat.full))
        else $error("queue overflow or underflow");

    // Relay bits beyond the fitted relays stay off
    a_relay_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[15:8] & ~RELAY_MASK) == 8'h00))
        else $error("relay bit set beyond fitted relays");

endmodule
